@@ rtl/rrdr_pkg.sv @@
// ----------------------------------------------------------------------------
// rrdr_pkg: shared types and constants
// Item layouts, operation and verdict codes, header limits, checksum patch.
// ----------------------------------------------------------------------------
`default_nettype none
package rrdr_pkg;

    localparam int BACKENDS_DEF  = 16;
    localparam int LISTENERS_DEF = 16;
    localparam int NUM_STATS     = 4;

    localparam logic [1:0] OP_PACKET   = 2'd0;
    localparam logic [1:0] OP_WR_BACK  = 2'd1;
    localparam logic [1:0] OP_WR_LSN   = 2'd2;
    localparam logic [1:0] OP_RD_STAT  = 2'd3;

    localparam logic [1:0] VERDICT_PASS = 2'd0;
    localparam logic [1:0] VERDICT_TX   = 2'd1;
    localparam logic [1:0] VERDICT_DONE = 2'd2;

    localparam logic [1:0] STAT_PROC  = 2'd0;
    localparam logic [1:0] STAT_REDIR = 2'd1;
    localparam logic [1:0] STAT_PASS  = 2'd2;
    localparam logic [1:0] STAT_ABORT = 2'd3;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [15:0] LEN_ETH       = 16'd14;
    localparam logic [15:0] LEN_IP        = 16'd34;
    localparam logic [15:0] LEN_TCP       = 16'd54;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] tcp_dest_port;
        logic [31:0] ip_dest_addr;
        logic [15:0] ip_checksum;
        logic [7:0]  table_index;
        logic [31:0] table_value;
        logic        entry_valid;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] new_dest_addr;
        logic [15:0] new_checksum;
        logic [3:0]  backend_slot;
        logic [63:0] stat_value;
    } out_item_t;

    // One's-complement update of the header sum for a new destination
    function automatic logic [15:0] patch_checksum(input logic [15:0] old_sum,
                                                   input logic [31:0] old_addr,
                                                   input logic [31:0] new_addr);
        logic [18:0] acc;
        logic [16:0] f1;
        logic [15:0] f2;
        acc = {3'b000, ~old_sum} + {3'b000, ~old_addr[15:0]} + {3'b000, ~old_addr[31:16]}
            + 19'(new_addr[15:0]) + 19'(new_addr[31:16]);
        f1  = 17'(acc[15:0]) + 17'(acc[18:16]);
        f2  = f1[15:0] + 16'(f1[16]);
        return ~f2;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rrdr_if.sv @@
// ----------------------------------------------------------------------------
// rrdr_if: item channels
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
`default_nettype none
interface rrdr_req_if import rrdr_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface rrdr_rsp_if import rrdr_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

@@ rtl/tcp_round_robin_dest_rewriter_top.sv @@
// ----------------------------------------------------------------------------
// tcp_round_robin_dest_rewriter_top: round-robin TCP destination rewriter
// Backend table in RAM, listener match, checksum patch and counters.
// ----------------------------------------------------------------------------
// Pipeline: request registered in stage 1, response in the output register;
// a stalled response holds stage 1. Throughput: one item per cycle unless
// the response stalls; the backend RAM reads the current and next slot each
// cycle so a packet right behind a rewrite sees the advanced slot.
// Reset: listener table, backend valid bits, slot pointer and counters clear at once; no clearing pass.
`default_nettype none
module tcp_round_robin_dest_rewriter_top import rrdr_pkg::*; #(
    parameter int BACKENDS  = BACKENDS_DEF,
    parameter int LISTENERS = LISTENERS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    rrdr_req_if.sink    req,
    rrdr_rsp_if.source  rsp
);
    localparam int BAW = $clog2(BACKENDS);

    logic            s1_valid_reg, s1_valid_next;
    in_item_t        s1_item_reg;
    logic            adv_reg, adv_next;
    logic [BAW-1:0]  ptr_reg, ptr_next, ptr_inc;
    logic [BACKENDS-1:0] bvalid_reg;
    logic [63:0]     stat_reg [NUM_STATS];
    logic            out_valid_reg;
    out_item_t       out_item_reg, out_item_next;

    logic            accept, s1_fire;
    logic            be_we, ls_we, hit;
    logic [31:0]     rd0, rd1, target;
    logic [NUM_STATS-1:0] inc;

    assign accept  = req.valid && req.ready;
    assign s1_fire = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign ptr_inc = (ptr_reg == BAW'(BACKENDS - 1)) ? '0 : ptr_reg + 1'b1;

    assign be_we = accept && req.item.operation == OP_WR_BACK
                 && 9'(req.item.table_index) < 9'(BACKENDS);
    assign ls_we = accept && req.item.operation == OP_WR_LSN
                 && 9'(req.item.table_index) < 9'(LISTENERS);

    rrdr_ram #(.WIDTH(32), .DEPTH(BACKENDS)) u_backend (
        .clk    (clk),
        .we     (be_we),
        .waddr  (req.item.table_index[BAW-1:0]),
        .wdata  (req.item.table_value),
        .raddr0 (ptr_reg),
        .raddr1 (ptr_inc),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    rrdr_listen #(.LISTENERS(LISTENERS)) u_listen (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ls_we),
        .widx  (req.item.table_index),
        .wport (req.item.table_value[15:0]),
        .wen   (req.item.entry_valid),
        .port  (s1_item_reg.tcp_dest_port),
        .hit   (hit)
    );

    // RAM data was read at last cycle's pointer; take the next slot if it moved
    always_comb
    begin
        target = adv_reg ? rd1 : rd0;
        if (!bvalid_reg[ptr_reg])
        begin
            target = '0;
        end
    end

    always_comb
    begin
        out_item_next.verdict       = VERDICT_DONE;
        out_item_next.new_dest_addr = s1_item_reg.ip_dest_addr;
        out_item_next.new_checksum  = s1_item_reg.ip_checksum;
        out_item_next.backend_slot  = '0;
        out_item_next.stat_value    = '0;
        inc      = '0;
        ptr_next = ptr_reg;
        case (s1_item_reg.operation)
            OP_PACKET:
            begin
                out_item_next.verdict = VERDICT_PASS;
                inc[STAT_PROC] = 1'b1;
                if (s1_item_reg.frame_length < LEN_ETH)
                begin
                end
                else if (s1_item_reg.ether_type != ETH_TYPE_IPV4)
                begin
                    inc[STAT_PASS] = 1'b1;
                end
                else if (s1_item_reg.frame_length < LEN_IP)
                begin
                end
                else if (s1_item_reg.ip_protocol != PROTO_TCP)
                begin
                    inc[STAT_PASS] = 1'b1;
                end
                else if (s1_item_reg.frame_length < LEN_TCP)
                begin
                end
                else if (!hit)
                begin
                    inc[STAT_PASS] = 1'b1;
                end
                else
                begin
                    out_item_next.backend_slot = 4'(ptr_reg);
                    if (target == '0)
                    begin
                        inc[STAT_ABORT] = 1'b1;
                    end
                    else
                    begin
                        out_item_next.verdict       = VERDICT_TX;
                        out_item_next.new_dest_addr = target;
                        out_item_next.new_checksum  = patch_checksum(
                            s1_item_reg.ip_checksum, s1_item_reg.ip_dest_addr, target);
                        inc[STAT_REDIR] = 1'b1;
                        ptr_next = ptr_inc;
                    end
                end
            end
            OP_RD_STAT:
            begin
                if (s1_item_reg.table_index < 8'(NUM_STATS))
                begin
                    out_item_next.stat_value = stat_reg[s1_item_reg.table_index[1:0]];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s1_valid_next = accept || (s1_valid_reg && !s1_fire);
    assign adv_next      = s1_fire && (ptr_next != ptr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            adv_reg       <= 1'b0;
            ptr_reg       <= '0;
            bvalid_reg    <= '0;
            for (int i = 0; i < NUM_STATS; i++)
            begin
                stat_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            adv_reg      <= adv_next;
            if (be_we)
            begin
                bvalid_reg[req.item.table_index[BAW-1:0]] <= 1'b1;
            end
            if (s1_fire)
            begin
                ptr_reg <= ptr_next;
                for (int i = 0; i < NUM_STATS; i++)
                begin
                    if (inc[i])
                    begin
                        stat_reg[i] <= stat_reg[i] + 64'd1;
                    end
                end
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req.item;
        end
        if (s1_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;
endmodule
`default_nettype wire

@@ rtl/rrdr_ram.sv @@
// ----------------------------------------------------------------------------
// rrdr_ram: generic RAM
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none
module rrdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr0,
    input  wire logic [AW-1:0]    raddr1,
    output logic      [WIDTH-1:0] rdata0,
    output logic      [WIDTH-1:0] rdata1
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end
endmodule
`default_nettype wire

@@ rtl/rrdr_listen.sv @@
// ----------------------------------------------------------------------------
// rrdr_listen: listener port table
// Entries with enable bits and a parallel port match.
// ----------------------------------------------------------------------------
`default_nettype none
module rrdr_listen import rrdr_pkg::*; #(
    parameter int LISTENERS = LISTENERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        we,
    input  wire logic [7:0]  widx,
    input  wire logic [15:0] wport,
    input  wire logic        wen,
    input  wire logic [15:0] port,
    output logic             hit
);
    logic [15:0] port_reg  [LISTENERS];
    logic        valid_reg [LISTENERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LISTENERS; i++)
            begin
                port_reg[i]  <= '0;
                valid_reg[i] <= 1'b0;
            end
        end
        else if (we)
        begin
            for (int i = 0; i < LISTENERS; i++)
            begin
                if (widx == 8'(i))
                begin
                    port_reg[i]  <= wport;
                    valid_reg[i] <= wen;
                end
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < LISTENERS; i++)
        begin
            hit = hit | (valid_reg[i] && port_reg[i] == port);
        end
    end
endmodule
`default_nettype wire

@@ rtl/rrdr_checker.sv @@
// ----------------------------------------------------------------------------
// rrdr_checker: port-level checks
// Watches the response channel of the rewriter.
// ----------------------------------------------------------------------------
`default_nettype none
module rrdr_checker import rrdr_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire out_item_t rsp_item
);
    // hold a stalled item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("response item changed while stalled");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_item.verdict != 2'd3)
        else $error("illegal verdict");

    a_tx_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.verdict == VERDICT_TX |-> rsp_item.new_dest_addr != '0
        && rsp_item.stat_value == '0)
        else $error("transmit with empty backend");

    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.verdict == VERDICT_DONE |-> rsp_item.backend_slot == '0)
        else $error("table operation reported a slot");
endmodule

bind tcp_round_robin_dest_rewriter_top rrdr_checker u_rrdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.item)
);
`default_nettype wire
